FILE: rtl/lfrd_pkg.sv
// lfrd_pkg: shared types and fixed codes for the link frame receiver and destuffer
// no dependencies; imported by link_frame_receiver_destuffer
`timescale 1ns / 1ps

package lfrd_pkg;

	// frame receiver state codes
	localparam logic [2:0] ST_START  = 3'd0;
	localparam logic [2:0] ST_FLAG   = 3'd1;
	localparam logic [2:0] ST_ADDR   = 3'd2;
	localparam logic [2:0] ST_CTRL   = 3'd3;
	localparam logic [2:0] ST_HDR_OK = 3'd4;
	localparam logic [2:0] ST_END    = 3'd5;

	// operation codes carried in the input tuser
	localparam logic [1:0] OP_BYTE   = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_TOGGLE = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_FLAG      = 3'd0;
	localparam logic [2:0] REG_ESCAPE    = 3'd1;
	localparam logic [2:0] REG_SENDER    = 3'd2;
	localparam logic [2:0] REG_RECEIVER  = 3'd3;
	localparam logic [2:0] REG_INFO_ZERO = 3'd4;
	localparam logic [2:0] REG_INFO_ONE  = 3'd5;

	// fixed supervisory and unnumbered control codes
	localparam logic [7:0] CTRL_SET  = 8'h03;
	localparam logic [7:0] CTRL_UA   = 8'h07;
	localparam logic [7:0] CTRL_RR0  = 8'hAA;
	localparam logic [7:0] CTRL_RR1  = 8'hAB;
	localparam logic [7:0] CTRL_REJ0 = 8'h54;
	localparam logic [7:0] CTRL_REJ1 = 8'h55;
	localparam logic [7:0] CTRL_DISC = 8'h0B;

	// escaped byte is the original with this bit flipped
	localparam logic [7:0] ESC_MASK = 8'h20;

	localparam int COUNT_W = 11;

	// one result transaction
	typedef struct packed {
		logic [2:0]         frame_state;
		logic               payload_valid;
		logic [7:0]         payload_byte;
		logic [COUNT_W-1:0] payload_count;
		logic               repeated_frame;
		logic [7:0]         last_control;
		logic               overflow;
	} result_t;

endpackage

FILE: rtl/link_frame_receiver_destuffer.sv
// link_frame_receiver_destuffer: byte-wide HDLC-like frame receiver with destuffing
// depends on lfrd_pkg for state, op and register codes and the result type
`timescale 1ns / 1ps

// The result of an input transaction appears on the master side in the following cycle.
// Throughput: one item per cycle when not stalled; each byte is decided combinationally.
// The input stalls only while a result waits on the master side; a new item enters in the
// same cycle as the held result is taken.
// Reset (arst_n low, asynchronous): receiver at start, counters and flags cleared,
// registers at their default values, no result pending.
module link_frame_receiver_destuffer #(
	parameter int PAYLOAD_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic [1:0]  s_tuser,  // [1:0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [2:0] frame_state, [10:3] payload_byte,
	                              // [21:11] payload_count, [22] repeated_frame,
	                              // [30:23] last_control, [31] overflow
	output logic        m_tuser,  // [0] payload_valid
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	import lfrd_pkg::*;

	// room is PAYLOAD_MAX+1 bytes, capped to what the counter holds
	localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
	localparam int LIMIT_RAW   = PAYLOAD_MAX + 1;
	localparam int LIMIT_INT   = (LIMIT_RAW > COUNT_MAX) ? COUNT_MAX : LIMIT_RAW;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);

	// configuration registers
	logic [7:0] flag_q, escape_q, sender_q, receiver_q, info0_q, info1_q;

	// frame state
	logic [2:0]         fsm_q, fsm_d;
	logic [7:0]         addr_q, addr_d;
	logic [7:0]         ctrl_q, ctrl_d;
	logic [7:0]         prev_q, prev_d;
	logic               rep_q, rep_d;
	logic               esc_q, esc_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic               ovf_q, ovf_d;

	// result register
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;

	logic       accept;
	logic       ctrl_is_info;
	logic       byte_is_info;
	logic       byte_ctrl_ok;
	logic [7:0] rx;
	logic [7:0] unstuffed;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign rx       = s_tdata;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q     <= 8'h7E;
			escape_q   <= 8'h7D;
			sender_q   <= 8'h03;
			receiver_q <= 8'h01;
			info0_q    <= 8'h00;
			info1_q    <= 8'h80;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLAG:      flag_q     <= cfg_data;
				REG_ESCAPE:    escape_q   <= cfg_data;
				REG_SENDER:    sender_q   <= cfg_data;
				REG_RECEIVER:  receiver_q <= cfg_data;
				REG_INFO_ZERO: info0_q    <= cfg_data;
				REG_INFO_ONE:  info1_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// control byte classification
	assign ctrl_is_info = (ctrl_q == info0_q) || (ctrl_q == info1_q);
	assign byte_is_info = (rx == info0_q) || (rx == info1_q);
	assign byte_ctrl_ok = byte_is_info || (rx inside {CTRL_SET, CTRL_UA, CTRL_RR0, CTRL_RR1,
		CTRL_REJ0, CTRL_REJ1, CTRL_DISC});

	// undo the escape on the byte after an escape
	always_comb begin
		unstuffed = rx;
		if (esc_q) begin
			if (rx == (flag_q ^ ESC_MASK)) begin
				unstuffed = flag_q;
			end else if (rx == (escape_q ^ ESC_MASK)) begin
				unstuffed = escape_q;
			end
		end
	end

	// next frame state and result for the item on the input
	always_comb begin
		fsm_d  = fsm_q;
		addr_d = addr_q;
		ctrl_d = ctrl_q;
		prev_d = prev_q;
		rep_d  = rep_q;
		esc_d  = esc_q;
		cnt_d  = cnt_q;
		ovf_d  = ovf_q;
		res_d.payload_valid = 1'b0;
		res_d.payload_byte  = 8'h00;
		case (s_tuser)
			OP_CLEAR: begin
				fsm_d  = ST_START;
				addr_d = 8'h00;
				cnt_d  = '0;
				rep_d  = 1'b0;
				esc_d  = 1'b0;
				ovf_d  = 1'b0;
			end
			OP_TOGGLE: begin
				prev_d = (prev_q == info0_q) ? info1_q : info0_q;
			end
			OP_BYTE: begin
				case (fsm_q)
					ST_START: begin
						if (rx == flag_q) fsm_d = ST_FLAG;
					end
					ST_FLAG: begin
						addr_d = rx;
						if (rx == sender_q || rx == receiver_q) fsm_d = ST_ADDR;
						else if (rx != flag_q) fsm_d = ST_START;
					end
					ST_ADDR: begin
						ctrl_d = rx;
						if (byte_ctrl_ok) fsm_d = ST_CTRL;
						else if (rx == flag_q) fsm_d = ST_FLAG;
						else fsm_d = ST_START;
					end
					ST_CTRL: begin
						if (rx == (addr_q ^ ctrl_q)) fsm_d = ST_HDR_OK;
						else if (rx == flag_q) fsm_d = ST_FLAG;
						else fsm_d = ST_START;
					end
					ST_HDR_OK: begin
						if (rx == flag_q) begin
							fsm_d  = ST_END;
							if (ctrl_is_info && ctrl_q == prev_q) rep_d = 1'b1;
							prev_d = ctrl_q;
						end else if (ctrl_is_info && addr_q == sender_q) begin
							if (rx == escape_q) begin
								esc_d = 1'b1;
							end else begin
								esc_d = 1'b0;
								if (cnt_q < COUNT_LIMIT) begin
									cnt_d = cnt_q + 1'b1;
									res_d.payload_valid = 1'b1;
									res_d.payload_byte  = unstuffed;
								end else begin
									ovf_d = 1'b1;
								end
							end
						end else begin
							fsm_d = ST_START;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		res_d.frame_state    = fsm_d;
		res_d.payload_count  = cnt_d;
		res_d.repeated_frame = rep_d;
		res_d.last_control   = prev_d;
		res_d.overflow       = ovf_d;
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q  <= ST_START;
			addr_q <= 8'h00;
			ctrl_q <= 8'h00;
			prev_q <= 8'h00;
			rep_q  <= 1'b0;
			esc_q  <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			fsm_q  <= fsm_d;
			addr_q <= addr_d;
			ctrl_q <= ctrl_d;
			prev_q <= prev_d;
			rep_q  <= rep_d;
			esc_q  <= esc_d;
			cnt_q  <= cnt_d;
			ovf_q  <= ovf_d;
		end
	end

	// result register, held while the master side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	// result packing
	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.payload_valid;
	assign m_tdata  = {res_q.overflow, res_q.last_control, res_q.repeated_frame,
		res_q.payload_count, res_q.payload_byte, res_q.frame_state};

	// a payload byte only comes out of a frame whose header checked
	a_payload_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (res_q.frame_state == ST_HDR_OK))
		else $error("payload byte outside an accepted frame");

	// the counter never passes the payload room
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_LIMIT)
		else $error("payload count beyond limit");

	// overflow only once the room is full
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == COUNT_LIMIT))
		else $error("overflow with room left");

	// a clear returns the receiver to start with an empty count
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_CLEAR) |=> (fsm_q == ST_START && cnt_q == '0 && !ovf_q))
		else $error("clear did not reset the frame");

	// bytes are ignored once the frame has ended
	a_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_BYTE && fsm_q == ST_END) |=> (fsm_q == ST_END))
		else $error("left end state without a clear");

endmodule
